/* design/dcuc_pkg.sv */
// shared constants and types for the drift-corrected uptime clock
package dcuc_pkg;

	localparam int unsigned SEC_W  = 32;
	localparam int unsigned USEC_W = 20;
	localparam int unsigned MS_W   = 32;

	localparam logic [USEC_W-1:0] USEC_PER_SEC   = 20'd1000000;
	localparam logic [USEC_W-1:0] USEC_MAX       = 20'd999999;
	localparam logic [USEC_W-1:0] WINDOW_DEFAULT = 20'd800000;

	// x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 20-bit x
	localparam int unsigned       RECIP_SHIFT = 40;
	localparam logic [30:0]       RECIP_1000  = 31'd1099511628;
	localparam logic [9:0]        MS_PER_SEC  = 10'd1000;

	// stream word widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 88;

	// config port
	localparam int unsigned ADDR_W = 3;
	localparam logic [0:0]  REG_FORWARD_WINDOW = 1'b0;

	typedef enum logic [1:0] {
		DRIFT_NONE     = 2'd0,
		DRIFT_FORWARD  = 2'd1,
		DRIFT_BACKWARD = 2'd2
	} drift_t;

	// saturate a microsecond value to the valid range
	function automatic logic [USEC_W-1:0] clamp_usec(input logic [USEC_W-1:0] v);
		clamp_usec = (v > USEC_MAX) ? USEC_MAX : v;
	endfunction

endpackage

/* design/drift_corrected_uptime_clock.sv */
// top level: drift-corrected elapsed time from raw clock sample words
// an accepted word passes stage 1 and stage 2 to its result word on the output register
// throughput: one word per cycle unless the output stalls; the elapsed-time update from the previous
// word closes on acceptance, the millisecond multiply and reciprocal divide take the two stages behind it
// reset: arst_n asynchronously clears the start flag, previous sample, running elapsed time
// and all stage valids, and sets the forward window to 800000 us
module drift_corrected_uptime_clock (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dcuc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] sample_sec, [51:32] sample_usec, [55:52] zero
	input  logic [dcuc_pkg::IN_DATA_W-1:0]     s_tdata,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] elapsed_sec, [51:32] elapsed_usec, [83:52] elapsed_ms,
	// [85:84] drift_seen, [87:86] zero
	output logic [dcuc_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import dcuc_pkg::*;

	logic              [USEC_W-1:0] window_q;
	logic                           started_q;
	logic              [SEC_W-1:0]  last_sec_q;
	logic              [USEC_W-1:0] last_usec_q;
	logic              [SEC_W-1:0]  el_sec_q;
	logic              [USEC_W-1:0] el_usec_q;

	logic                           in_acc;
	logic              [SEC_W-1:0]  in_sec;
	logic              [USEC_W-1:0] in_usec;
	logic signed       [USEC_W:0]   du_raw;
	logic              [USEC_W-1:0] d_usec;
	logic                           d_borrow;
	logic              [SEC_W:0]    d_sec;
	logic                           is_back;
	logic                           is_fwd;
	drift_t                         drift;
	logic              [SEC_W-1:0]  add_sec;
	logic              [USEC_W-1:0] add_usec;
	logic              [USEC_W:0]   su_raw;
	logic                           su_carry;
	logic              [USEC_W-1:0] nx_usec;
	logic              [SEC_W-1:0]  nx_sec;

	logic                           v_s1, v_s2, v_q;
	logic                           rdy_s1, rdy_s2, rdy_q;
	logic              [SEC_W-1:0]  sec_s1, sec_s2;
	logic              [USEC_W-1:0] usec_s1, usec_s2;
	drift_t                         drift_s1, drift_s2;
	logic              [MS_W-1:0]   msb_s2;
	logic              [9:0]        msq_s2;
	logic              [50:0]       recip_prod;
	logic              [41:0]       sec_prod;
	logic              [SEC_W-1:0]  out_sec_q;
	logic              [USEC_W-1:0] out_usec_q;
	logic              [MS_W-1:0]   out_ms_q;
	drift_t                         out_drift_q;

	// config register write and read-back
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FORWARD_WINDOW) ? {12'd0, window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_DEFAULT;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FORWARD_WINDOW) begin
			window_q <= clamp_usec(pwdata[USEC_W-1:0]);
		end
	end

	// stage handshakes: each stage moves when the one behind it has room
	assign rdy_q    = !v_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_q;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign in_acc   = s_tvalid && s_tready;

	assign in_sec  = s_tdata[SEC_W-1:0];
	assign in_usec = clamp_usec(s_tdata[SEC_W+USEC_W-1:SEC_W]);

	// step since the previous sample, as seconds and microseconds
	always_comb begin
		du_raw   = $signed({1'b0, in_usec}) - $signed({1'b0, last_usec_q});
		d_borrow = du_raw[USEC_W];
		d_usec   = d_borrow ? USEC_W'(du_raw[USEC_W-1:0] + USEC_PER_SEC)
		                    : du_raw[USEC_W-1:0];
		d_sec    = {1'b0, in_sec} - {1'b0, last_sec_q} - {{SEC_W{1'b0}}, d_borrow};
		is_back  = d_sec[SEC_W];
		is_fwd   = !is_back && (d_sec[SEC_W-1:0] != '0 || d_usec > window_q);
	end

	// elapsed time advances by the step, by the window on a forward jump, not at all backward
	always_comb begin
		priority if (is_back) begin
			drift    = DRIFT_BACKWARD;
			add_sec  = '0;
			add_usec = '0;
		end else if (is_fwd) begin
			drift    = DRIFT_FORWARD;
			add_sec  = '0;
			add_usec = window_q;
		end else begin
			drift    = DRIFT_NONE;
			add_sec  = d_sec[SEC_W-1:0];
			add_usec = d_usec;
		end
		su_raw   = {1'b0, el_usec_q} + {1'b0, add_usec};
		su_carry = su_raw >= {1'b0, USEC_PER_SEC};
		nx_usec  = su_carry ? USEC_W'(su_raw - {1'b0, USEC_PER_SEC}) : su_raw[USEC_W-1:0];
		nx_sec   = el_sec_q + add_sec + {{(SEC_W-1){1'b0}}, su_carry};
	end

	// running state, updated on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			last_sec_q  <= '0;
			last_usec_q <= '0;
			el_sec_q    <= '0;
			el_usec_q   <= '0;
		end else if (in_acc) begin
			started_q   <= 1'b1;
			last_sec_q  <= in_sec;
			last_usec_q <= in_usec;
			el_sec_q    <= started_q ? nx_sec : '0;
			el_usec_q   <= started_q ? nx_usec : '0;
		end
	end

	// stage 1: elapsed time and drift of the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sec_s1   <= started_q ? nx_sec : '0;
			usec_s1  <= started_q ? nx_usec : '0;
			drift_s1 <= started_q ? drift : DRIFT_NONE;
		end
	end

	// stage 2: seconds times 1000 and microseconds over 1000
	assign sec_prod   = 42'(sec_s1) * 42'(MS_PER_SEC);
	assign recip_prod = 51'(usec_s1) * 51'(RECIP_1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sec_s2   <= sec_s1;
			usec_s2  <= usec_s1;
			drift_s2 <= drift_s1;
			msb_s2   <= sec_prod[MS_W-1:0];
			msq_s2   <= recip_prod[RECIP_SHIFT+9:RECIP_SHIFT];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_q) begin
			v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_q && v_s2) begin
			out_sec_q   <= sec_s2;
			out_usec_q  <= usec_s2;
			out_ms_q    <= msb_s2 + {{(MS_W-10){1'b0}}, msq_s2};
			out_drift_q <= drift_s2;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = {2'b00, out_drift_q, out_ms_q, out_usec_q, out_sec_q};

endmodule

/* design/dcuc_checker.sv */
// port-level checks for the drift-corrected uptime clock, bound to the top level
module dcuc_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dcuc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dcuc_pkg::*;

	logic [SEC_W-1:0]  o_sec;
	logic [USEC_W-1:0] o_usec;
	logic [MS_W-1:0]   o_ms;
	logic [1:0]        o_drift;
	logic [41:0]       exp_ms;

	assign o_sec   = m_tdata[31:0];
	assign o_usec  = m_tdata[51:32];
	assign o_ms    = m_tdata[83:52];
	assign o_drift = m_tdata[85:84];
	assign exp_ms  = 42'(o_sec) * 42'd1000 + 42'(o_usec / 20'd1000);

	// a stalled word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// microsecond part stays normalized
	a_usec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o_usec < 20'd1000000)
		else $error("elapsed_usec out of range");

	// drift code is never the unused value
	a_drift: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o_drift != 2'd3)
		else $error("drift_seen carries an unused code");

	// milliseconds agree with seconds and microseconds
	a_ms: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o_ms == exp_ms[31:0])
		else $error("elapsed_ms inconsistent with elapsed_sec and elapsed_usec");

endmodule

bind drift_corrected_uptime_clock dcuc_port_checks u_dcuc_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* dv/dcuc_checker.sv */
// checker for the drift-corrected uptime clock: predicts every result word and compares it
module dcuc_checker
	import dcuc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    errors,
	output int                    pending,
	output int                    words_checked,
	output int                    fwd_seen,
	output int                    back_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
		logic [MS_W-1:0]   ms;
		drift_t            drift;
	} elapsed_t;

	localparam longint unsigned USEC_IN_SEC = 64'd1000000;
	// microsecond totals wrap at 2^32 seconds
	localparam longint unsigned WRAP_USEC   = 64'd4294967296 * 64'd1000000;
	localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * REG_FORWARD_WINDOW);

	// predictor state
	logic [USEC_W-1:0] window;
	bit                started;
	longint unsigned   last_total;
	longint unsigned   ref_total;

	elapsed_t elapsed_q[$];
	elapsed_t want;

	function automatic logic [USEC_W-1:0] sat_usec(input logic [USEC_W-1:0] v);
		return (v > USEC_MAX) ? USEC_MAX : v;
	endfunction

	// advance the reference on drift and work out the elapsed time for one sample
	function automatic elapsed_t predict_elapsed(input logic [SEC_W-1:0] sec,
	                                             input logic [USEC_W-1:0] usec_raw);
		longint unsigned s;
		longint unsigned limit;
		longint unsigned e;
		longint unsigned e_sec;
		longint unsigned e_usec;
		longint unsigned ms_full;
		elapsed_t res;
		s = 64'(sec) * USEC_IN_SEC + 64'(sat_usec(usec_raw));
		res.drift = DRIFT_NONE;
		if (!started) begin
			started = 1'b1;
			ref_total = s;
		end else begin
			limit = last_total + 64'(window);
			if (s > limit) begin
				ref_total = (ref_total + (s - limit)) % WRAP_USEC;
				res.drift = DRIFT_FORWARD;
			end else if (s < last_total) begin
				ref_total = (ref_total + WRAP_USEC - (last_total - s)) % WRAP_USEC;
				res.drift = DRIFT_BACKWARD;
			end
		end
		last_total = s;
		e = (s + WRAP_USEC - ref_total) % WRAP_USEC;
		e_sec = e / USEC_IN_SEC;
		e_usec = e % USEC_IN_SEC;
		ms_full = e_sec * 64'd1000 + e_usec / 64'd1000;
		res.sec = e_sec[SEC_W-1:0];
		res.usec = e_usec[USEC_W-1:0];
		res.ms = ms_full[MS_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string name, input longint unsigned exp_v,
	                           input longint unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
		end
	endtask

	// watch config writes, sample words and result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window = WINDOW_DEFAULT;
			started = 1'b0;
			last_total = 0;
			ref_total = 0;
			elapsed_q.delete();
			errors = 0;
			pending = 0;
			words_checked = 0;
			fwd_seen = 0;
			back_seen = 0;
		end else begin
			// result word against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (elapsed_q.size() == 0) begin
					errors++;
					$display("%0t mismatch: expected no word, actual word %h", $time, m_tdata);
				end else begin
					want = elapsed_q.pop_front();
					check_field("elapsed_sec", want.sec, m_tdata[31:0]);
					check_field("elapsed_usec", want.usec, m_tdata[51:32]);
					check_field("elapsed_ms", want.ms, m_tdata[83:52]);
					check_field("drift_seen", want.drift, m_tdata[85:84]);
					words_checked++;
				end
			end
			// sample word
			if (s_tvalid && s_tready) begin
				want = predict_elapsed(s_tdata[31:0], s_tdata[51:32]);
				if (want.drift == DRIFT_FORWARD)
					fwd_seen++;
				if (want.drift == DRIFT_BACKWARD)
					back_seen++;
				elapsed_q.push_back(want);
			end
			// forward window register; other addresses hold nothing
			if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
				window = sat_usec(pwdata[USEC_W-1:0]);
			pending = elapsed_q.size();
		end
	end

endmodule

/* dv/drift_corrected_uptime_clock_tb.sv */
// testbench top for the drift-corrected uptime clock: stimulus, handshake pacing and verdict
module drift_corrected_uptime_clock_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import dcuc_pkg::*;

	localparam longint unsigned USEC_IN_SEC = 64'd1000000;
	localparam longint unsigned WRAP_USEC   = 64'd4294967296 * 64'd1000000;
	localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * REG_FORWARD_WINDOW);
	// first address past the register list
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * (REG_FORWARD_WINDOW + 1));
	localparam int RANDOM_PER_PHASE = 175;
	localparam int HOLD_CYCLES = 64;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [31:0] sample_sec, [51:32] sample_usec, [55:52] zero
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [31:0] elapsed_sec, [51:32] elapsed_usec, [83:52] elapsed_ms,
	// [85:84] drift_seen, [87:86] zero
	logic [OUT_DATA_W-1:0] m_tdata;

	int errors;
	int pending;
	int words_checked;
	int fwd_seen;
	int back_seen;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int n_sent = 0;
	int n_windows = 1;
	longint unsigned wall_usec;

	drift_corrected_uptime_clock i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dcuc_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.errors        (errors),
		.pending       (pending),
		.words_checked (words_checked),
		.fwd_seen      (fwd_seen),
		.back_seen     (back_seen)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// result side: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// offer one sample word and wait until it is taken
	task automatic send_sample(input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= IN_DATA_W'({$urandom, $urandom});
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, usec, sec};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// next sample from a wall clock that mostly runs forward with occasional jumps
	task automatic send_random();
		int roll;
		logic [USEC_W-1:0] usec;
		roll = $urandom_range(99);
		if (roll < 65)
			wall_usec = (wall_usec + 64'($urandom_range(1200000))) % WRAP_USEC;
		else if (roll < 75)
			wall_usec = (wall_usec + 64'($urandom_range(1, 5000)) * USEC_IN_SEC
				+ 64'($urandom_range(999999))) % WRAP_USEC;
		else if (roll < 88)
			wall_usec = (wall_usec + WRAP_USEC - 64'($urandom_range(1, 3000000))) % WRAP_USEC;
		else
			wall_usec = 64'($urandom) * USEC_IN_SEC + 64'($urandom_range(999999));
		usec = USEC_W'(wall_usec % USEC_IN_SEC);
		// out-of-range microseconds now and then
		if ($urandom_range(19) == 0)
			usec = USEC_W'($urandom_range(1000000, 1048575));
		send_sample(SEC_W'(wall_usec / USEC_IN_SEC), usec);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every expected word has come out and the pipeline has drained
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_window(input logic [USEC_W-1:0] w);
		wait_idle();
		apb_write(WINDOW_ADDR, {12'($urandom), w});
		n_windows++;
	endtask

	// stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first sample, saturated microseconds, window edges, wrap of the reference
		send_sample(32'd100, 20'hFFFFF);
		send_sample(32'd100, 20'd999999);
		send_sample(32'd101, 20'd799999);
		send_sample(32'd102, 20'd600000);
		send_sample(32'd102, 20'd500000);
		send_sample(32'd0, 20'd0);
		send_sample(32'hFFFFFFFF, 20'd999999);
		send_sample(32'hFFFFFFFF, 20'd1000000);
		send_sample(32'd0, 20'd0);
		send_sample(32'h55555555, 20'h55555);
		send_sample(32'hAAAAAAAA, 20'hAAAAA);

		// write past the register list must leave the window alone
		wait_idle();
		apb_write(UNUSED_ADDR, 32'hFFFFFFFF);
		send_sample(32'hAAAAAAAA, 20'd999999);

		// zero window: any step forward is drift
		set_window(20'd0);
		send_sample(32'd1000, 20'd0);
		send_sample(32'd1000, 20'd1);
		send_sample(32'd1000, 20'd1);

		// oversized window saturates
		set_window(20'hFFFFF);
		send_sample(32'd1001, 20'd0);
		send_sample(32'd1002, 20'd1);

		set_window(20'd999999);
		send_sample(32'd1003, 20'd0);
		wall_usec = 64'd1003 * USEC_IN_SEC;

		// random phases with different pacing and windows
		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: set_window(USEC_W'($urandom_range(999999)));
				1: set_window(USEC_W'($urandom_range(2000)));
				2: set_window(20'd999999);
				default: set_window(USEC_W'($urandom));
			endcase
			idle_pct = (phase == 1) ? 75 : (phase == 3) ? 21 : 0;
			stall_pct = (phase == 2) ? 75 : (phase == 3) ? 21 : 0;
			// long hold-off on the result side so the input backs up
			if (phase == 0)
				hold_ask++;
			repeat (RANDOM_PER_PHASE) send_random();
		end

		idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		repeat (2) @(posedge clk);

		$display("covered %0d samples, %0d result words checked, %0d window settings",
			n_sent, words_checked, n_windows);
		$display("drift corrections seen: %0d forward, %0d backward", fwd_seen, back_seen);
		if (pending != 0)
			$display("%0t %0d result words never arrived", $time, pending);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* drift_corrected_uptime_clock.f */
design/dcuc_pkg.sv
design/drift_corrected_uptime_clock.sv
design/dcuc_checker.sv
dv/dcuc_checker.sv
dv/drift_corrected_uptime_clock_tb.sv
